// File: hw/rtl/jlcg_pkg.sv
// shared constants and types for the 48-bit lcg bounded random generator
package jlcg_pkg;

  localparam int StateW    = 48;
  localparam int DrawW     = 31;
  localparam int DigitW    = 8;
  localparam int MulDigits = 5;
  localparam int MulExtW   = DigitW * MulDigits;
  localparam int DivSteps  = DrawW;

  localparam logic [StateW-1:0]  LcgMul    = 48'h0005_DEEC_E66D;
  localparam logic [StateW-1:0]  LcgAdd    = 48'h0000_0000_000B;
  localparam logic [MulExtW-1:0] LcgMulExt = 40'h05_DEEC_E66D;
  localparam logic [32:0]        Low31Max  = 33'h0_7FFF_FFFF;

  typedef enum logic [1:0] {
    KIND_RESEED  = 2'd0,
    KIND_RAW     = 2'd1,
    KIND_BOUNDED = 2'd2
  } kind_t;

endpackage

// File: hw/rtl/java_lcg_bounded_random.sv
// top level: 48-bit lcg with raw and bounded draws, sequenced over shared multiply and divide units
//
// usage
//   input channel (in_valid / in_ready) carries one transaction per command:
//   kind 0 reseeds (no result), kind 1 returns the top in_bit_count bits of
//   the advanced state, kind 2 returns a value below in_bound; kind 3 is dropped
//   result channel (out_valid / out_ready) carries out_value, one per draw
// sequencing
//   reseed and dropped commands are taken while in_ready stays high
//   raw and power-of-two bounded draws: the byte-serial state multiply runs
//   its 5 steps and raises its done flag, the result moves through the done
//   state into the output register, and in_ready returns high as out_valid rises
//   other bounded draws: the 31-step remainder unit runs after the multiply,
//   and each rejected draw repeats multiply and remainder
//   a zero bound goes straight to the done state without a multiply and
//   leaves the state untouched
// reset
//   synchronous active-low rst_n; state loads the seed-zero value, both
//   channels go idle
// stalls
//   a finished result sits in the output register while the next command is
//   taken; a second result waits in the done state until out_ready frees it
module java_lcg_bounded_random import jlcg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_kind,
  input  logic [47:0]        in_seed_value,
  input  logic [5:0]         in_bit_count,
  input  logic [30:0]        in_bound,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_value
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } st_t;

  st_t               st_r, st_nxt;
  logic [StateW-1:0] state_r, state_nxt;
  kind_t             kind_r, kind_nxt;
  logic [5:0]        bit_count_r, bit_count_nxt;
  logic [DrawW-1:0]  bound_r, bound_nxt;
  logic [31:0]       res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       out_value_r, out_value_nxt;

  // shared unit hookup
  logic              mul_start, mul_done;
  logic [StateW-1:0] mul_in, mul_prod;
  logic              div_start, div_done;
  logic [DrawW-1:0]  div_rem;

  // draw decode from the freshly advanced state
  logic [DrawW-1:0]  mul_draw;
  logic [5:0]        nsat;
  logic [5:0]        raw_sh;
  logic [31:0]       raw_val;
  logic [61:0]       pw_prod;
  logic              bound_pow2;
  logic [DrawW-1:0]  cur_draw;
  logic [32:0]       check_sum;
  logic              redraw;

  assign mul_draw   = mul_prod[StateW-1 -: DrawW];
  assign nsat       = (bit_count_r > 6'd32) ? 6'd32 : bit_count_r;
  assign raw_sh     = 6'd32 - nsat;
  assign raw_val    = (bit_count_r == 6'd0) ? 32'd0 : (mul_prod[StateW-1 -: 32] >> raw_sh);
  assign pw_prod    = {31'd0, bound_r} * {31'd0, mul_draw};  // bound is a power of two here
  assign bound_pow2 = (bound_r & (bound_r - 31'd1)) == 31'd0;

  // java rejection check: draw - rem + bound - 1 must stay within 31 bits
  assign cur_draw  = state_r[StateW-1 -: DrawW];
  assign check_sum = {2'b00, cur_draw} - {2'b00, div_rem} + {2'b00, bound_r} - 33'd1;
  assign redraw    = check_sum > Low31Max;

  always_comb begin
    st_nxt        = st_r;
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    bit_count_nxt = bit_count_r;
    bound_nxt     = bound_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    mul_start     = 1'b0;
    mul_in        = state_r;
    div_start     = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          kind_nxt      = kind_t'(in_kind);
          bit_count_nxt = in_bit_count;
          bound_nxt     = in_bound;
          case (in_kind)
            KIND_RESEED: begin
              state_nxt = in_seed_value ^ LcgMul;
            end
            KIND_RAW: begin
              mul_start = 1'b1;
              st_nxt    = ST_MUL;
            end
            KIND_BOUNDED: begin
              if (in_bound == 31'd0) begin
                // zero bound answers 0 and leaves the state alone
                res_nxt = 32'd0;
                st_nxt  = ST_DONE;
              end else begin
                mul_start = 1'b1;
                st_nxt    = ST_MUL;
              end
            end
            default: begin
              // unused command, dropped
            end
          endcase
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          state_nxt = mul_prod;
          if (kind_r == KIND_RAW) begin
            res_nxt = raw_val;
            st_nxt  = ST_DONE;
          end else if (bound_pow2) begin
            res_nxt = {1'b0, pw_prod[61 -: DrawW]};
            st_nxt  = ST_DONE;
          end else begin
            div_start = 1'b1;
            st_nxt    = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (redraw) begin
            mul_start = 1'b1;
            st_nxt    = ST_MUL;
          end else begin
            res_nxt = {1'b0, div_rem};
            st_nxt  = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = res_r;
          st_nxt        = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      state_r     <= LcgMul;
      kind_r      <= KIND_RESEED;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      state_r     <= state_nxt;
      kind_r      <= kind_nxt;
      out_valid_r <= out_valid_nxt;
    end
    bit_count_r <= bit_count_nxt;
    bound_r     <= bound_nxt;
    res_r       <= res_nxt;
    out_value_r <= out_value_nxt;
  end

  jlcg_mul u_mul (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (mul_start),
    .multiplicand (mul_in),
    .done         (mul_done),
    .product      (mul_prod)
  );

  jlcg_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (mul_draw),
    .divisor   (bound_r),
    .done      (div_done),
    .remainder (div_rem)
  );

  assign in_ready  = (st_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_value = $signed(out_value_r);

endmodule

// File: hw/rtl/jlcg_mul.sv
// iterative lcg step unit: state * multiplier + increment mod 2^48, one byte of the multiplier a cycle
module jlcg_mul import jlcg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [StateW-1:0] multiplicand,
  output logic              done,
  output logic [StateW-1:0] product
);

  logic [StateW-1:0] a_r, a_nxt;
  logic [StateW-1:0] acc_r, acc_nxt;
  logic [2:0]        idx_r, idx_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DigitW-1:0] digit;

  assign digit = LcgMulExt[{idx_r, 3'b000} +: DigitW];

  always_comb begin
    a_nxt    = a_r;
    acc_nxt  = acc_r;
    idx_nxt  = idx_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt    = multiplicand;
      acc_nxt  = LcgAdd;
      idx_nxt  = 3'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = acc_r + StateW'(a_r * digit);
      a_nxt   = a_r << DigitW;
      idx_nxt = idx_r + 3'd1;
      if (idx_r == 3'(MulDigits - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      idx_r  <= 3'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      idx_r  <= idx_nxt;
    end
    a_r   <= a_nxt;
    acc_r <= acc_nxt;
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

// File: hw/rtl/jlcg_div.sv
// restoring remainder unit, one quotient bit a cycle
module jlcg_div import jlcg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DrawW-1:0] dividend,
  input  logic [DrawW-1:0] divisor,
  output logic             done,
  output logic [DrawW-1:0] remainder
);

  logic [DrawW-1:0] dvd_r, dvd_nxt;
  logic [DrawW-1:0] dsr_r, dsr_nxt;
  logic [DrawW-1:0] rem_r, rem_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DrawW:0]   trial;
  logic             fits;

  assign trial = {rem_r, dvd_r[DrawW-1]};
  assign fits  = trial >= {1'b0, dsr_r};

  always_comb begin
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      rem_nxt  = '0;
      cnt_nxt  = 5'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? DrawW'(trial - {1'b0, dsr_r}) : trial[DrawW-1:0];
      dvd_nxt = dvd_r << 1;
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'(DivSteps - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

// File: hw/rtl/jlcg_checker.sv
// port-level checker for the lcg generator, bound to the top level
module jlcg_checker import jlcg_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [1:0]         in_kind,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_value
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value))
    else $error("result changed while stalled");

  // a raw draw occupies the sequencer
  a_raw_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind == KIND_RAW |=> !in_ready)
    else $error("raw draw did not block input");

  // reseed completes in the accepting cycle
  a_reseed_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind == KIND_RESEED |=> in_ready)
    else $error("reseed blocked input");

  // a new result only follows a cycle of sequencer work
  a_out_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without work");

endmodule

bind java_lcg_bounded_random jlcg_checker u_jlcg_checker (.*);
